// ===== sv/bmul_pkg.sv =====
// ----------------------------------------------------------------------------
// bmul_pkg
// Shared constants and types for the binary32 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
package bmul_pkg;
    localparam int unsigned W_WORD = 32;
    localparam logic [7:0]  EXP_MAX  = 8'd255;
    localparam logic [31:0] QNAN_DEF = 32'h7FC0_0000;
    localparam logic [31:0] QUIET    = 32'h0040_0000;
    localparam logic [30:0] INF_MAG  = 31'h7F80_0000;
    typedef logic [W_WORD-1:0] t_word;
endpackage
`default_nettype wire

// ===== sv/binary32_multiplier_unit.sv =====
// ----------------------------------------------------------------------------
// binary32_multiplier_unit
// IEEE 754 binary32 multiply, round to nearest even, five register stages.
// ----------------------------------------------------------------------------
//  channel  | ports                                     | handshake
//  input    | i_start, i_operand_a, i_operand_b, o_busy | start && !busy
//  result   | o_valid, o_product                        | strobe, one cycle
//
// One item may enter every cycle. The pipeline stages are unpack/normalize,
// 24x24 multiply, normalize/shift, align/round and pack. busy is always
// low since the receiver cannot stall. Synchronous active-low reset
// clears the valid bits only.
`default_nettype none
module binary32_multiplier_unit (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire bmul_pkg::t_word i_operand_a,
    input  wire bmul_pkg::t_word i_operand_b,
    output logic                 o_busy,
    output logic                 o_valid,
    output bmul_pkg::t_word      o_product
);
    import bmul_pkg::*;

    // valid chain
    logic [4:0] r_vld;

    // ---------------- stage 1: classify and normalize ----------------
    logic        r1_spec, r1_sign;
    logic [31:0] r1_spec_val;
    logic [23:0] r1_sa, r1_sb;
    logic signed [9:0] r1_ea, r1_eb;

    function automatic logic [4:0] lzc23(input logic [22:0] m);
        logic [4:0] n;
        n = 5'd23;
        for (int i = 0; i < 23; i++) begin
            if (m[i]) n = 5'(22 - i);
        end
        return n;
    endfunction

    logic [7:0] ca, cb;
    logic a_nan, b_nan, a_zero, b_zero, n1_spec;
    logic [31:0] n1_spec_val;
    logic [4:0] lza, lzb;
    assign ca = i_operand_a[30:23];
    assign cb = i_operand_b[30:23];
    assign a_nan  = (ca == EXP_MAX) && (i_operand_a[22:0] != '0);
    assign b_nan  = (cb == EXP_MAX) && (i_operand_b[22:0] != '0);
    assign a_zero = i_operand_a[30:0] == '0;
    assign b_zero = i_operand_b[30:0] == '0;
    assign lza = lzc23(i_operand_a[22:0]);
    assign lzb = lzc23(i_operand_b[22:0]);

    // special results decided up front
    always_comb begin
        n1_spec = 1'b1;
        if (a_nan)
            n1_spec_val = i_operand_a | QUIET;
        else if (b_nan)
            n1_spec_val = i_operand_b | QUIET;
        else if (ca == EXP_MAX || cb == EXP_MAX)
            n1_spec_val = (a_zero || b_zero) ? QNAN_DEF
                : {i_operand_a[31] ^ i_operand_b[31], INF_MAG};
        else if (a_zero || b_zero)
            n1_spec_val = {i_operand_a[31] ^ i_operand_b[31], 31'd0};
        else begin
            n1_spec     = 1'b0;
            n1_spec_val = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_spec     <= n1_spec;
        r1_spec_val <= n1_spec_val;
        r1_sign     <= i_operand_a[31] ^ i_operand_b[31];
        if (ca != 8'd0) begin
            r1_sa <= {1'b1, i_operand_a[22:0]};
            r1_ea <= $signed({2'b00, ca}) - 10'sd127;
        end else begin
            r1_sa <= {1'b0, i_operand_a[22:0]} << (lza + 5'd1);
            r1_ea <= -10'sd126 - $signed({5'd0, lza}) - 10'sd1;
        end
        if (cb != 8'd0) begin
            r1_sb <= {1'b1, i_operand_b[22:0]};
            r1_eb <= $signed({2'b00, cb}) - 10'sd127;
        end else begin
            r1_sb <= {1'b0, i_operand_b[22:0]} << (lzb + 5'd1);
            r1_eb <= -10'sd126 - $signed({5'd0, lzb}) - 10'sd1;
        end
    end

    // ---------------- stage 2: multiply ----------------
    logic        r2_spec, r2_sign;
    logic [31:0] r2_spec_val;
    logic [47:0] r2_m;
    logic signed [9:0] r2_e;
    always_ff @(posedge i_clk) begin
        r2_spec     <= r1_spec;
        r2_spec_val <= r1_spec_val;
        r2_sign     <= r1_sign;
        r2_m        <= 48'(r1_sa) * 48'(r1_sb);
        r2_e        <= r1_ea + r1_eb + 10'sd127;
    end

    // ---------------- stage 3: normalize, compute shift ----------------
    logic        r3_spec, r3_sign, r3_ovf, r3_sub;
    logic [31:0] r3_spec_val;
    logic [47:0] r3_m;
    logic [5:0]  r3_sh;
    logic [7:0]  r3_e;
    logic signed [9:0] e3;
    logic signed [10:0] s3;
    always_comb begin
        e3 = r2_m[47] ? r2_e + 10'sd1 : r2_e;
        s3 = 11'sd25 - 11'(e3);
    end
    always_ff @(posedge i_clk) begin
        r3_spec     <= r2_spec;
        r3_spec_val <= r2_spec_val;
        r3_sign     <= r2_sign;
        r3_m        <= r2_m[47] ? r2_m : {r2_m[46:0], 1'b0};
        r3_ovf      <= e3 >= 10'sd255;
        r3_sub      <= e3 < 10'sd1;
        r3_e        <= (e3 < 10'sd1) ? 8'd0 : e3[7:0];
        if (e3 >= 10'sd1)
            r3_sh <= 6'd24;
        else if (s3 > 11'sd49)
            r3_sh <= 6'd49;
        else
            r3_sh <= s3[5:0];
    end

    // ---------------- stage 4: align and round ----------------
    // remainder and half are one bit wider so a shift of 49 keeps its half
    logic        r4_spec, r4_sign, r4_ovf, r4_sub;
    logic [31:0] r4_spec_val;
    logic [24:0] r4_sig;
    logic [7:0]  r4_e;
    logic [47:0] sig4;
    logic [48:0] rem4, half4, mask4;
    logic        up4;
    always_comb begin
        sig4  = r3_m >> r3_sh;
        mask4 = (49'd1 << r3_sh) - 49'd1;
        half4 = 49'd1 << (r3_sh - 6'd1);
        rem4  = {1'b0, r3_m} & mask4;
        up4   = (rem4 > half4) || (rem4 == half4 && sig4[0]);
    end
    always_ff @(posedge i_clk) begin
        r4_spec     <= r3_spec;
        r4_spec_val <= r3_spec_val;
        r4_sign     <= r3_sign;
        r4_ovf      <= r3_ovf;
        r4_sub      <= r3_sub;
        r4_e        <= r3_e;
        r4_sig      <= sig4[24:0] + 25'(up4);
    end

    // ---------------- stage 5: pack ----------------
    logic [31:0] r5_res;
    logic [8:0]  e5;
    logic [22:0] f5;
    always_comb begin
        e5 = {1'b0, r4_e};
        f5 = r4_sig[22:0];
        if (r4_sig[24]) begin
            e5 = e5 + 9'd1;
            f5 = r4_sig[23:1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (r4_spec)
            r5_res <= r4_spec_val;
        else if (r4_ovf)
            r5_res <= {r4_sign, INF_MAG};
        else if (r4_sub)
            r5_res <= {r4_sign, 7'd0, r4_sig[23:0]};
        else if (e5 >= 9'd255)
            r5_res <= {r4_sign, INF_MAG};
        else
            r5_res <= {r4_sign, e5[7:0], f5};
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_start};
        end
    end

    assign o_busy    = 1'b0;
    assign o_valid   = r_vld[4];
    assign o_product = r5_res;
endmodule
`default_nettype wire
